// File: rtl/cbl_pkg.sv
// Package for the byte-budget LRU cache: result kinds, field widths and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none
package cbl_pkg;
    localparam int TAG_W    = 32;
    localparam int COST_W   = 32;
    localparam int TOTAL_W  = 38;
    localparam int BUDGET_W = 40;
    localparam int CNT_W    = 32;
    localparam int OCNT_W   = 6;

    typedef logic [1:0] t_kind;
    localparam t_kind K_LOOKUP = 2'd0;
    localparam t_kind K_INSERT = 2'd1;
    localparam t_kind K_EVICT  = 2'd2;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef struct packed {
        logic  load;
        logic  match;
        logic  lookup_upd;
        logic  drop;
        logic  evict;
        logic  store;
        logic  pend;
        t_kind pend_kind;
        logic  pend_last;
        logic  pend_key;
        logic  emit;
    } t_cmd;

    typedef struct packed {
        logic action;
        logic present;
        logic over;
        logic full;
        logic too_big;
        logic out_free;
        logic p_last;
    } t_stat;
endpackage
`default_nettype wire

// File: rtl/cbl_if.sv
// Channel interfaces of the LRU cache: input items, result items, budget writes.
// Depends on cbl_pkg.
`default_nettype none
interface cbl_item_if import cbl_pkg::*;;
    logic              valid;
    logic              ready;
    logic              action;
    logic [TAG_W-1:0]  key_tag;
    logic [COST_W-1:0] entry_cost;
    logic              entry_present;
    modport source (output valid, action, key_tag, entry_cost, entry_present, input ready);
    modport sink (input valid, action, key_tag, entry_cost, entry_present, output ready);
endinterface

interface cbl_result_if import cbl_pkg::*;;
    logic               valid;
    logic               ready;
    t_kind              kind;
    logic               hit;
    logic [TAG_W-1:0]   result_tag;
    logic [TOTAL_W-1:0] total_bytes;
    logic [OCNT_W-1:0]  entry_count;
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   miss_count;
    logic               last;
    modport source (output valid, kind, hit, result_tag, total_bytes, entry_count,
                    hit_count, miss_count, last, input ready);
    modport sink (input valid, kind, hit, result_tag, total_bytes, entry_count,
                  hit_count, miss_count, last, output ready);
endinterface

interface cbl_cfg_if import cbl_pkg::*;;
    logic                valid;
    logic                ready;
    logic [BUDGET_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/cbl_datapath.sv
// Datapath of the LRU cache: entry table, recency ranks, totals, counters and
// the result register. Depends on cbl_pkg; driven by cbl_ctrl commands.
`default_nettype none
module cbl_datapath import cbl_pkg::*; #(
    parameter int ENTRIES = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_action,
    input  wire logic [TAG_W-1:0]    i_key_tag,
    input  wire logic [COST_W-1:0]   i_entry_cost,
    input  wire logic                i_entry_present,
    input  wire logic                i_cfg_valid,
    input  wire logic [BUDGET_W-1:0] i_cfg_data,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output t_kind                    o_kind,
    output logic                     o_hit,
    output logic [TAG_W-1:0]         o_result_tag,
    output logic [TOTAL_W-1:0]       o_total_bytes,
    output logic [OCNT_W-1:0]        o_entry_count,
    output logic [CNT_W-1:0]         o_hit_count,
    output logic [CNT_W-1:0]         o_miss_count,
    output logic                     o_last
);
    localparam int RW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [TAG_W-1:0]    r_tag [ENTRIES];
    logic [COST_W-1:0]   r_cost [ENTRIES];
    logic [ENTRIES-1:0]  r_valid;
    logic [RW-1:0]       r_rank [ENTRIES];
    logic [TOTAL_W-1:0]  r_total;
    logic [CW-1:0]       r_held;
    logic [CNT_W-1:0]    r_hits;
    logic [CNT_W-1:0]    r_misses;
    logic [BUDGET_W-1:0] r_budget;
    logic                r_found;
    logic [RW-1:0]       r_slot;
    logic                r_act;
    logic                r_present;
    logic [TAG_W-1:0]    r_key;
    logic [COST_W-1:0]   r_cost_in;
    t_kind               r_p_kind;
    logic                r_p_hit;
    logic                r_p_last;
    logic [TAG_W-1:0]    r_p_tag;
    logic                r_out_valid;
    t_kind               r_o_kind;
    logic                r_o_hit;
    logic [TAG_W-1:0]    r_o_tag;
    logic [TOTAL_W-1:0]  r_o_total;
    logic [OCNT_W-1:0]   r_o_count;
    logic [CNT_W-1:0]    r_o_hits;
    logic [CNT_W-1:0]    r_o_misses;
    logic                r_o_last;

    logic                n_found;
    logic [RW-1:0]       n_slot;
    logic                w_old_found;
    logic [RW-1:0]       w_old_slot;
    logic [RW-1:0]       w_free_slot;
    logic                w_drop_en;
    logic [RW-1:0]       w_drop_slot;
    logic [RW-1:0]       w_drop_rank;
    logic [BUDGET_W-1:0] w_need;

    always_comb begin
        n_found     = 1'b0;
        n_slot      = '0;
        w_old_found = 1'b0;
        w_old_slot  = '0;
        w_free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_tag[i] == r_key) begin
                n_found = 1'b1;
                n_slot  = RW'(i);
            end
            if (r_valid[i] && ((CW+1)'(r_rank[i]) + (CW+1)'(1) == (CW+1)'(r_held))) begin
                w_old_found = 1'b1;
                w_old_slot  = RW'(i);
            end
            if (!r_valid[i]) begin
                w_free_slot = RW'(i);
            end
        end
    end

    assign w_drop_slot = i_cmd.evict ? w_old_slot : r_slot;
    assign w_drop_en   = (i_cmd.evict && w_old_found) || (i_cmd.drop && r_found);
    assign w_drop_rank = r_rank[w_drop_slot];
    assign w_need      = BUDGET_W'(r_total) + BUDGET_W'(r_cost_in);

    always_comb begin
        o_stat.action   = r_act;
        o_stat.present  = r_present;
        o_stat.over     = (r_held != '0) && (w_need > r_budget);
        o_stat.full     = r_held >= CW'(ENTRIES);
        o_stat.too_big  = BUDGET_W'(r_cost_in) > r_budget;
        o_stat.out_free = !r_out_valid || i_out_ready;
        o_stat.p_last   = r_p_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_total     <= '0;
            r_held      <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_budget    <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_budget <= i_cfg_data;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.match) begin
                r_found <= n_found;
            end
            if (i_cmd.lookup_upd) begin
                if (r_found) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_valid[i] && r_rank[i] < r_rank[r_slot]) begin
                            r_rank[i] <= r_rank[i] + RW'(1);
                        end
                    end
                    r_rank[r_slot] <= '0;
                    if (r_hits != '1) begin
                        r_hits <= r_hits + CNT_W'(1);
                    end
                end else if (r_misses != '1) begin
                    r_misses <= r_misses + CNT_W'(1);
                end
            end
            if (w_drop_en) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && r_rank[i] > w_drop_rank) begin
                        r_rank[i] <= r_rank[i] - RW'(1);
                    end
                end
                r_valid[w_drop_slot] <= 1'b0;
                r_rank[w_drop_slot]  <= '0;
                r_total <= r_total - TOTAL_W'(r_cost[w_drop_slot]);
                r_held  <= r_held - CW'(1);
            end
            if (i_cmd.store) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + RW'(1);
                    end
                end
                r_valid[w_free_slot] <= 1'b1;
                r_rank[w_free_slot]  <= '0;
                r_total <= r_total + TOTAL_W'(r_cost_in);
                r_held  <= r_held + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act     <= i_action;
            r_present <= i_entry_present;
            r_key     <= i_key_tag;
            r_cost_in <= i_entry_cost;
        end
        if (i_cmd.match) begin
            r_slot <= n_slot;
        end
        if (i_cmd.store) begin
            r_tag[w_free_slot]  <= r_key;
            r_cost[w_free_slot] <= r_cost_in;
        end
        if (i_cmd.pend) begin
            r_p_kind <= i_cmd.pend_kind;
            r_p_hit  <= (i_cmd.pend_kind == K_LOOKUP) && r_found;
            r_p_last <= i_cmd.pend_last;
            r_p_tag  <= i_cmd.pend_key ? r_key : r_tag[w_old_slot];
        end
        if (i_cmd.emit) begin
            r_o_kind   <= r_p_kind;
            r_o_hit    <= r_p_hit;
            r_o_tag    <= r_p_tag;
            r_o_last   <= r_p_last;
            r_o_total  <= r_total;
            r_o_count  <= OCNT_W'(r_held);
            r_o_hits   <= r_hits;
            r_o_misses <= r_misses;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_o_kind;
    assign o_hit         = r_o_hit;
    assign o_result_tag  = r_o_tag;
    assign o_total_bytes = r_o_total;
    assign o_entry_count = r_o_count;
    assign o_hit_count   = r_o_hits;
    assign o_miss_count  = r_o_misses;
    assign o_last        = r_o_last;
endmodule
`default_nettype wire

// File: rtl/cbl_ctrl.sv
// Controller of the LRU cache: sequences match, update, eviction and result
// steps for one item. Depends on cbl_pkg.
`default_nettype none
module cbl_ctrl import cbl_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MATCH = 5'b00010,
        S_APPLY = 5'b00100,
        S_CHECK = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                if (i_stat.action == ACT_INSERT && !i_stat.present) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (i_stat.action == ACT_LOOKUP) begin
                    o_cmd.lookup_upd = 1'b1;
                    o_cmd.pend       = 1'b1;
                    o_cmd.pend_kind  = K_LOOKUP;
                    o_cmd.pend_last  = 1'b1;
                    o_cmd.pend_key   = 1'b1;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.pend = 1'b1;
                n_state    = S_EMIT;
                priority if (i_stat.over || i_stat.full) begin
                    o_cmd.evict     = 1'b1;
                    o_cmd.pend_kind = K_EVICT;
                end else if (i_stat.too_big) begin
                    o_cmd.pend_kind = K_EVICT;
                    o_cmd.pend_last = 1'b1;
                    o_cmd.pend_key  = 1'b1;
                end else begin
                    o_cmd.store     = 1'b1;
                    o_cmd.pend_kind = K_INSERT;
                    o_cmd.pend_last = 1'b1;
                    o_cmd.pend_key  = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.p_last ? S_IDLE : S_CHECK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// File: rtl/cost_budget_lru_cache_top.sv
// Top level of the byte-budget LRU cache: joins controller and datapath.
// Depends on cbl_pkg, cbl_if, cbl_ctrl and cbl_datapath.
//
// Use: items enter on i_item (lookup or insert), results leave on o_result,
// and the byte budget is written on i_cfg, which is always ready.
// A lookup gives one result and passes the match, apply and emit states
// before the next item can be accepted.
// An insert gives one eviction report per evicted entry and then an insert
// done result (or an eviction report for an entry larger than the budget).
// For each result of an insert the controller first updates the table in the
// check state and then loads the output register in the emit state. An insert
// without an entry gives no result and returns to idle from the match state.
// One item is worked on at a time; the next is accepted once the last result
// of the current item sits in the output register.
// When the receiver stalls, the result waits in the output register and the
// controller holds before loading the next result.
// Reset empties the table, clears counters, totals and the budget at once.
`default_nettype none
module cost_budget_lru_cache_top import cbl_pkg::*; #(
    parameter int ENTRIES = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cbl_item_if.sink    i_item,
    cbl_result_if.source o_result,
    cbl_cfg_if.sink     i_cfg
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_item.ready = w_in_ready;
    assign i_cfg.ready  = 1'b1;

    cbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cbl_datapath #(.ENTRIES(ENTRIES)) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_action        (i_item.action),
        .i_key_tag       (i_item.key_tag),
        .i_entry_cost    (i_item.entry_cost),
        .i_entry_present (i_item.entry_present),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_data      (i_cfg.data),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_kind          (o_result.kind),
        .o_hit           (o_result.hit),
        .o_result_tag    (o_result.result_tag),
        .o_total_bytes   (o_result.total_bytes),
        .o_entry_count   (o_result.entry_count),
        .o_hit_count     (o_result.hit_count),
        .o_miss_count    (o_result.miss_count),
        .o_last          (o_result.last)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.entry_count <= OCNT_W'(ENTRIES))
        else $error("entry count above table size");
    a_lookup_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.kind == K_LOOKUP |-> o_result.last)
        else $error("lookup answer not marked last");
    a_hit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.hit |-> o_result.kind == K_LOOKUP)
        else $error("hit set outside a lookup answer");
    a_insert_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.kind == K_INSERT |-> o_result.entry_count != '0)
        else $error("insert done with an empty table");
`endif
endmodule
`default_nettype wire

// File: verif/cbl_tb_pkg.sv
// Testbench-side constants for the byte-budget LRU cache tests.
// Depends on cbl_pkg for field widths.
`timescale 1ns / 100ps
package cbl_tb_pkg;
    import cbl_pkg::*;
    localparam int TB_ENTRIES = 32;

    typedef struct packed {
        t_kind              kind;
        logic               hit;
        logic [TAG_W-1:0]   tag;
        logic [TOTAL_W-1:0] total;
        logic [OCNT_W-1:0]  count;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   misses;
        logic               last;
    } t_cache_result;
endpackage

// File: verif/testbench.sv
// Testbench of the byte-budget LRU cache: drives lookups, inserts and budget writes,
// predicts every result with its own model of the table, and checks each result.
// Depends on cbl_pkg, cbl_if, cbl_tb_pkg and the cost_budget_lru_cache_top RTL.
`timescale 1ns / 100ps
module testbench;
    import cbl_pkg::*;
    import cbl_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   failed = 1'b0;
    int   stall_hold = 0;
    int   result_total = 0;

    cbl_item_if   item_ch ();
    cbl_result_if result_ch ();
    cbl_cfg_if    cfg_ch ();

    cost_budget_lru_cache_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_result(result_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state of the cache.
    logic [TAG_W-1:0]   m_tag [TB_ENTRIES];
    logic [COST_W-1:0]  m_cost [TB_ENTRIES];
    bit                 m_valid [TB_ENTRIES];
    int                 m_rank [TB_ENTRIES];
    logic [TOTAL_W-1:0] m_total;
    logic [CNT_W-1:0]   m_hits;
    logic [CNT_W-1:0]   m_misses;
    int                 m_count;
    logic [BUDGET_W-1:0] m_budget;

    t_cache_result expected_results[$];

    function automatic void push_result(t_kind kind, logic hit, logic [TAG_W-1:0] tag);
        t_cache_result r;
        r.kind = kind;
        r.hit = hit;
        r.tag = tag;
        r.total = m_total;
        r.count = m_count[OCNT_W-1:0];
        r.hits = m_hits;
        r.misses = m_misses;
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic int find_key(logic [TAG_W-1:0] tag);
        for (int i = 0; i < TB_ENTRIES; i++) begin
            if (m_valid[i] && m_tag[i] == tag) return i;
        end
        return -1;
    endfunction

    function automatic void remove_slot(int s);
        int r;
        r = m_rank[s];
        for (int i = 0; i < TB_ENTRIES; i++) begin
            if (m_valid[i] && m_rank[i] > r) m_rank[i]--;
        end
        m_valid[s] = 0;
        m_rank[s] = 0;
        m_total = m_total - m_cost[s];
        if (m_count > 0) m_count--;
    endfunction

    function automatic void evict_least_recent();
        logic [TAG_W-1:0] tag;
        for (int i = 0; i < TB_ENTRIES; i++) begin
            if (m_valid[i] && m_rank[i] + 1 == m_count) begin
                tag = m_tag[i];
                remove_slot(i);
                push_result(K_EVICT, 1'b0, tag);
                return;
            end
        end
    endfunction

    function automatic void predict_cache(logic action, logic [TAG_W-1:0] key,
                                          logic [COST_W-1:0] cost, logic present);
        int s;
        int before_n;
        before_n = expected_results.size();
        if (action == ACT_LOOKUP) begin
            s = find_key(key);
            if (s >= 0) begin
                for (int i = 0; i < TB_ENTRIES; i++) begin
                    if (m_valid[i] && m_rank[i] < m_rank[s]) m_rank[i]++;
                end
                m_rank[s] = 0;
                if (m_hits != '1) m_hits++;
            end else if (m_misses != '1) begin
                m_misses++;
            end
            push_result(K_LOOKUP, s >= 0, key);
        end else begin
            if (!present) return;
            s = find_key(key);
            if (s >= 0) remove_slot(s);
            while (m_count > 0 && ({2'b0, m_total} + cost) > m_budget) evict_least_recent();
            if (m_count >= TB_ENTRIES) evict_least_recent();
            if (cost > m_budget) begin
                push_result(K_EVICT, 1'b0, key);
            end else begin
                for (s = 0; s < TB_ENTRIES && m_valid[s]; s++) ;
                if (s < TB_ENTRIES) begin
                    for (int i = 0; i < TB_ENTRIES; i++) begin
                        if (m_valid[i]) m_rank[i]++;
                    end
                    m_tag[s] = key;
                    m_cost[s] = cost;
                    m_valid[s] = 1;
                    m_rank[s] = 0;
                    m_total = m_total + cost;
                    m_count++;
                end
                push_result(K_INSERT, 1'b0, key);
            end
        end
        if (expected_results.size() > before_n)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    // Valid stays high after an item; whoever pauses the sender lowers it.
    task automatic send_item(logic action, logic [TAG_W-1:0] key,
                             logic [COST_W-1:0] cost, logic present);
        item_ch.valid <= 1'b1;
        item_ch.action <= action;
        item_ch.key_tag <= key;
        item_ch.entry_cost <= cost;
        item_ch.entry_present <= present;
        do @(posedge i_clk); while (!item_ch.ready);
        predict_cache(action, key, cost, present);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        item_ch.valid <= 1'b0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_budget(logic [BUDGET_W-1:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        m_budget = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic test_directed();
        write_budget(40'd1000);
        send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1'b0);
        send_item(ACT_INSERT, 32'hFFFF_FFFF, 32'd400, 1'b1);
        send_item(ACT_INSERT, 32'd0, 32'd0, 1'b1);
        send_item(ACT_INSERT, 32'd5, 32'd100, 1'b0);
        send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(ACT_LOOKUP, 32'd5, 32'd0, 1'b0);
        send_item(ACT_INSERT, 32'd7, 32'd500, 1'b1);
        send_item(ACT_INSERT, 32'hFFFF_FFFF, 32'd300, 1'b1);
        send_item(ACT_INSERT, 32'd9, 32'd600, 1'b1);
        send_item(ACT_INSERT, 32'd11, 32'd1001, 1'b1);
        send_item(ACT_INSERT, 32'd12, 32'd1000, 1'b1);
        write_budget(40'd0);
        send_item(ACT_INSERT, 32'd13, 32'd0, 1'b1);
        send_item(ACT_INSERT, 32'd14, 32'd1, 1'b1);
        write_budget('1);
        send_item(ACT_INSERT, 32'd15, 32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < 34; i++) send_item(ACT_INSERT, 32'd100 + i, 32'd10, 1'b1);
        send_item(ACT_LOOKUP, 32'd100, 32'd0, 1'b0);
        send_item(ACT_LOOKUP, 32'd120, 32'd0, 1'b0);
        write_budget(40'd200);
        send_item(ACT_INSERT, 32'd50, 32'd200, 1'b1);
    endtask

    task automatic test_random(int n_items);
        int burst;
        logic [TAG_W-1:0] key;
        logic [COST_W-1:0] cost;
        for (int k = 0; k < n_items; k++) begin
            burst = $urandom_range(0, 9);
            if (burst < 7) key = $urandom_range(0, 40);
            else key = $urandom;
            case ($urandom_range(0, 5))
                0: cost = $urandom;
                1: cost = $urandom_range(0, 1);
                default: cost = $urandom_range(1, 80);
            endcase
            send_item(1'($urandom_range(0, 1)), key, cost, $urandom_range(0, 9) != 0);
            sender_gap();
        end
    endtask

    task automatic test_budget_sweep();
        write_budget(40'd300);
        test_random(120);
        write_budget({8'h0, 32'hFFFF_FFFF});
        test_random(120);
        write_budget(40'd60);
        test_random(100);
    endtask

    task automatic test_backpressure();
        stall_hold = 300;
        for (int i = 0; i < 30; i++) send_item(1'($urandom_range(0, 1)), $urandom_range(0, 20),
                                               $urandom_range(1, 40), 1'b1);
        wait_drained();
        test_random(60);
    endtask

    initial begin
        for (int i = 0; i < TB_ENTRIES; i++) begin
            m_valid[i] = 0;
            m_rank[i] = 0;
            m_tag[i] = '0;
            m_cost[i] = '0;
        end
        m_total = '0;
        m_hits = '0;
        m_misses = '0;
        m_count = 0;
        m_budget = '0;
        item_ch.valid = 1'b0;
        item_ch.action = ACT_LOOKUP;
        item_ch.key_tag = '0;
        item_ch.entry_cost = '0;
        item_ch.entry_present = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_budget_sweep();
        test_backpressure();
        wait_drained();
        if (!failed && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Receiver: a stall pattern of its own, plus one long hold when asked.
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold > 0) begin
                result_ch.ready <= 1'b0;
                stall_hold--;
            end else if (($time / 2000) % 3 == 0) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= $urandom_range(0, 2) != 0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_cache_result exp_r;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            result_total++;
            if (expected_results.size() == 0) begin
                $error("unexpected result, tag %h", result_ch.result_tag);
                failed = 1'b1;
            end else begin
                exp_r = expected_results.pop_front();
                if (result_ch.kind !== exp_r.kind) begin
                    $error("kind expected %0d actual %0d", exp_r.kind, result_ch.kind);
                    failed = 1'b1;
                end
                if (result_ch.hit !== exp_r.hit) begin
                    $error("hit expected %0d actual %0d", exp_r.hit, result_ch.hit);
                    failed = 1'b1;
                end
                if (result_ch.result_tag !== exp_r.tag) begin
                    $error("result_tag expected %h actual %h", exp_r.tag, result_ch.result_tag);
                    failed = 1'b1;
                end
                if (result_ch.total_bytes !== exp_r.total) begin
                    $error("total_bytes expected %0d actual %0d", exp_r.total,
                           result_ch.total_bytes);
                    failed = 1'b1;
                end
                if (result_ch.entry_count !== exp_r.count) begin
                    $error("entry_count expected %0d actual %0d", exp_r.count,
                           result_ch.entry_count);
                    failed = 1'b1;
                end
                if (result_ch.hit_count !== exp_r.hits) begin
                    $error("hit_count expected %0d actual %0d", exp_r.hits, result_ch.hit_count);
                    failed = 1'b1;
                end
                if (result_ch.miss_count !== exp_r.misses) begin
                    $error("miss_count expected %0d actual %0d", exp_r.misses,
                           result_ch.miss_count);
                    failed = 1'b1;
                end
                if (result_ch.last !== exp_r.last) begin
                    $error("last expected %0d actual %0d", exp_r.last, result_ch.last);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
